>>> hdl/orl_pkg.sv
// orl_pkg: shared types and codes for the ordered record list
// no dependencies
`timescale 1ns / 1ps

package orl_pkg;

    localparam int KEY_W  = 32;
    localparam int NAME_W = 160;

    typedef logic [1:0] op_t;
    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_DELETE = 2'd1;
    localparam op_t OP_DUMP   = 2'd2;
    localparam op_t OP_NONE   = 2'd3;

    typedef logic [1:0] stat_t;
    localparam stat_t ST_OK       = 2'd0;
    localparam stat_t ST_NOTFOUND = 2'd1;
    localparam stat_t ST_FULL     = 2'd2;
    localparam stat_t ST_EMPTY    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request fields
        logic do_ins;    // shift chain and insert
        logic do_del;    // shift chain and delete
        logic dump_clr;  // reset dump pointer
        logic dump_step; // advance dump pointer
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic dump_last;
    } dp_stat_t;

endpackage

>>> hdl/orl_datapath.sv
// orl_datapath: chain of record cells, count and dump pointer
// depends on orl_pkg
`timescale 1ns / 1ps

module orl_datapath
    import orl_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int NAME_BYTES = 20,
    parameter int CW         = $clog2(DEPTH + 1),
    parameter int IW         = $clog2(DEPTH)
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic signed [KEY_W-1:0]  in_key,
    input  logic [NAME_W-1:0]        in_name,
    input  logic [7:0]               in_pos,
    output logic signed [KEY_W-1:0]  rd_key,
    output logic [NAME_W-1:0]        rd_name,
    output logic [CW-1:0]            count
);

    localparam int NB = NAME_BYTES * 8;

    logic [KEY_W-1:0]  key_reg  [DEPTH];
    logic [NAME_W-1:0] name_reg [DEPTH];
    logic [CW-1:0]     cnt_reg;
    logic [IW-1:0]     ptr_reg;
    logic [KEY_W-1:0]  key_q;
    logic [NAME_W-1:0] name_q;
    logic [7:0]        pos_q;
    logic [CW-1:0]     at;
    logic [DEPTH-1:0]  match;
    logic [DEPTH-1:0]  before_hit;
    logic [NAME_W-1:0] name_mask;

    assign name_mask = (NB >= NAME_W) ? {NAME_W{1'b1}}
                     : ({NAME_W{1'b1}} >> (NAME_W - NB));

    // insert place
    always_comb
    begin
        if (pos_q == 8'd1 || cnt_reg == '0)
            at = '0;
        else if (pos_q >= 8'd2 && pos_q <= 8'(cnt_reg))
            at = CW'(pos_q - 8'd1);
        else
            at = cnt_reg;
    end

    // per-cell key compare, first-match prefix
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            match[i] = (key_reg[i] == key_q) && (CW'(i) < cnt_reg);
        before_hit[0] = 1'b0;
        for (int i = 1; i < DEPTH; i++)
            before_hit[i] = before_hit[i-1] | match[i-1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_q  <= in_key;
            name_q <= in_name & name_mask;
            pos_q  <= in_pos;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cmd.do_ins)
            begin
                if (CW'(i) == at)
                begin
                    key_reg[i]  <= key_q;
                    name_reg[i] <= name_q;
                end
                else if (CW'(i) > at && i > 0)
                begin
                    key_reg[i]  <= key_reg[i-1];
                    name_reg[i] <= name_reg[i-1];
                end
            end
            else if (cmd.do_del && i < DEPTH - 1 && (before_hit[i] | match[i]))
            begin
                key_reg[i]  <= key_reg[i+1];
                name_reg[i] <= name_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            if (cmd.do_ins)
                cnt_reg <= cnt_reg + 1'b1;
            else if (cmd.do_del)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.dump_clr)
                ptr_reg <= '0;
            else if (cmd.dump_step)
                ptr_reg <= ptr_reg + 1'b1;
        end
    end

    assign stat.full      = (cnt_reg >= CW'(DEPTH));
    assign stat.empty     = (cnt_reg == '0);
    assign stat.hit       = |match;
    assign stat.dump_last = (CW'(ptr_reg) + 1'b1 == cnt_reg);
    assign rd_key         = key_reg[ptr_reg];
    assign rd_name        = name_reg[ptr_reg];
    assign count          = cnt_reg;

endmodule

>>> hdl/orl_ctrl.sv
// orl_ctrl: request sequencer and output valid flag
// depends on orl_pkg
`timescale 1ns / 1ps

module orl_ctrl
    import orl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  op_t      in_op,
    input  logic     out_ready,
    output logic     out_busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     res_load,
    output logic     res_data,
    output stat_t    res_status,
    output logic     res_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DUMP = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg;
    logic   ov_reg, ov_next;
    logic   can_emit;

    assign can_emit = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_busy = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        res_load   = 1'b0;
        res_data   = 1'b0;
        res_status = ST_OK;
        res_last   = 1'b1;
        ov_next    = ov_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_op != OP_NONE)
                begin
                    cmd.load     = 1'b1;
                    cmd.dump_clr = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_emit)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (stat.full)
                                res_status = ST_FULL;
                            else
                                cmd.do_ins = 1'b1;
                        end
                        OP_DELETE:
                        begin
                            if (stat.hit)
                                cmd.do_del = 1'b1;
                            else
                                res_status = ST_NOTFOUND;
                        end
                        default:
                        begin
                            if (stat.empty)
                                res_status = ST_EMPTY;
                            else
                            begin
                                res_data       = 1'b1;
                                res_last       = stat.dump_last;
                                cmd.dump_step  = 1'b1;
                                if (!stat.dump_last)
                                    state_next = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (can_emit)
                begin
                    res_load      = 1'b1;
                    res_data      = 1'b1;
                    res_last      = stat.dump_last;
                    cmd.dump_step = 1'b1;
                    if (stat.dump_last)
                        state_next = S_IDLE;
                end
            end
            S_WAIT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        if (res_load)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= in_op;
    end

endmodule

>>> hdl/ordered_record_list_top.sv
// ordered_record_list_top: top level of the ordered record list
// depends on orl_pkg, orl_ctrl, orl_datapath
`timescale 1ns / 1ps

// Ordered list of up to DEPTH records (signed 32-bit key, NAME_BYTES-byte
// name). Insert places a record by one-based position (1 or empty list goes
// to the head, 2..length goes before that record, anything else appends);
// a full list drops the insert with status 2. Delete removes the first record
// with a matching key or answers status 1. Dump emits each record in order,
// last marking the final one; an empty list gives one status-3 result.
// Op code 3 is swallowed with no result. Every other request is taken in
// S_IDLE and runs in S_EXEC once the output register is free: insert and
// delete finish there because the record chain compares and shifts all cells
// at once; a dump emits its first record there and the rest from S_DUMP, one
// record per cycle unless the output stalls, via the single dump read pointer.
// Results sit in an output register, so a stalled consumer holds the block.
// No clearing pass: the record cells are only read below the record count.

module ordered_record_list_top
    import orl_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int NAME_BYTES = 20
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              op,
    input  logic signed [31:0]      entry_key,
    input  logic [63:0]             name_part0,
    input  logic [63:0]             name_part1,
    input  logic [31:0]             name_part2,
    input  logic [7:0]              position,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      out_key,
    output logic [63:0]             out_name0,
    output logic [63:0]             out_name1,
    output logic [31:0]             out_name2,
    output logic [1:0]              status,
    output logic                    last,
    output logic [4:0]              length_now
);

    localparam int CW = $clog2(DEPTH + 1);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic signed [31:0] rd_key;
    logic [NAME_W-1:0]  rd_name;
    logic [CW-1:0]      count;
    logic               res_load, res_data, res_last;
    stat_t              res_status;
    logic [CW-1:0]      cnt_after;

    // control: one-hot sequencer, owns the output valid flag
    orl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_op      (op),
        .out_ready  (out_ready),
        .out_busy   (out_valid),
        .stat       (stat),
        .cmd        (cmd),
        .res_load   (res_load),
        .res_data   (res_data),
        .res_status (res_status),
        .res_last   (res_last)
    );

    // record chain
    orl_datapath #(
        .DEPTH      (DEPTH),
        .NAME_BYTES (NAME_BYTES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .in_key  (entry_key),
        .in_name ({name_part2, name_part1, name_part0}),
        .in_pos  (position),
        .rd_key  (rd_key),
        .rd_name (rd_name),
        .count   (count)
    );

    // length after the operation that is being reported
    always_comb
    begin
        if (cmd.do_ins)
            cnt_after = count + 1'b1;
        else if (cmd.do_del)
            cnt_after = count - 1'b1;
        else
            cnt_after = count;
    end

    // output register, loaded whenever a result is produced
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_key    <= res_data ? rd_key : '0;
            out_name0  <= res_data ? rd_name[63:0] : '0;
            out_name1  <= res_data ? rd_name[127:64] : '0;
            out_name2  <= res_data ? rd_name[159:128] : '0;
            status     <= res_status;
            last       <= res_last;
            length_now <= 5'(cnt_after);
        end
    end

endmodule

>>> bench/tb.sv
// tb: self-checking bench for ordered_record_list_top
// depends on orl_pkg and the ordered_record_list_top rtl
`timescale 1ns / 1ps

// keeps its own copy of the record list, predicts every result of each
// accepted request and checks results in order against that prediction
class list_scoreboard;
    localparam int CAP = 16;

    // expected result fields, one entry per predicted result
    typedef struct {
        logic [31:0]  key;
        logic [63:0]  n0;
        logic [63:0]  n1;
        logic [31:0]  n2;
        orl_pkg::stat_t st;
        logic         lst;
        logic [4:0]   len;
    } result_t;

    logic [31:0]  keys [CAP];
    logic [159:0] names [CAP];
    int           count;
    result_t      pending [$];
    int           errors;

    function new();
        count  = 0;
        errors = 0;
    endfunction

    function void push(logic [31:0] k, logic [159:0] nm, orl_pkg::stat_t st, logic lst);
        result_t r;
        r.key = k;
        r.n0  = nm[63:0];
        r.n1  = nm[127:64];
        r.n2  = nm[159:128];
        r.st  = st;
        r.lst = lst;
        r.len = count[4:0];
        pending.push_back(r);
    endfunction

    // update the list for one accepted request and queue its results
    function void note_request(orl_pkg::op_t op, logic [31:0] k, logic [159:0] nm,
                               logic [7:0] pos);
        int at;
        if (op == orl_pkg::OP_INSERT) begin
            if (count >= CAP)
            begin
                push(0, 0, orl_pkg::ST_FULL, 1);
                return;
            end
            if (pos == 1 || count == 0)
                at = 0;
            else if (pos >= 2 && pos <= count)
                at = pos - 1;
            else
                at = count;
            for (int i = count; i > at; i--)
            begin
                keys[i]  = keys[i-1];
                names[i] = names[i-1];
            end
            keys[at]  = k;
            names[at] = nm;
            count++;
            push(0, 0, orl_pkg::ST_OK, 1);
        end
        else if (op == orl_pkg::OP_DELETE) begin
            at = count;
            for (int i = count - 1; i >= 0; i--)
                if (keys[i] == k)
                    at = i;
            if (at == count)
            begin
                push(0, 0, orl_pkg::ST_NOTFOUND, 1);
                return;
            end
            for (int i = at; i + 1 < count; i++)
            begin
                keys[i]  = keys[i+1];
                names[i] = names[i+1];
            end
            count--;
            push(0, 0, orl_pkg::ST_OK, 1);
        end
        else if (op == orl_pkg::OP_DUMP) begin
            if (count == 0)
                push(0, 0, orl_pkg::ST_EMPTY, 1);
            for (int i = 0; i < count; i++)
                push(keys[i], names[i], orl_pkg::ST_OK, i + 1 == count);
        end
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(logic [31:0] k, logic [63:0] n0, logic [63:0] n1,
                      logic [31:0] n2, logic [1:0] st, logic lst,
                      logic [4:0] len);
        result_t e;
        if (pending.size() == 0)
        begin
            report("result with nothing expected");
            return;
        end
        e = pending.pop_front();
        if (k !== e.key)
            report($sformatf("out_key %h want %h", k, e.key));
        if (n0 !== e.n0 || n1 !== e.n1 || n2 !== e.n2)
            report($sformatf("name %h_%h_%h want %h_%h_%h", n2, n1, n0, e.n2, e.n1, e.n0));
        if (st !== e.st)
            report($sformatf("status %0d want %0d", st, e.st));
        if (lst !== e.lst)
            report($sformatf("last %b want %b", lst, e.lst));
        if (len !== e.len)
            report($sformatf("length_now %0d want %0d", len, e.len));
    endtask
endclass

module tb;
    import orl_pkg::*;

    localparam int  RANDOM_REQS = 250;
    localparam longint CYCLE_LIMIT = 2000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [31:0] entry_key;
    logic [63:0]        name_part0;
    logic [63:0]        name_part1;
    logic [31:0]        name_part2;
    logic [7:0]         position;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_key;
    logic [63:0]        out_name0;
    logic [63:0]        out_name1;
    logic [31:0]        out_name2;
    logic [1:0]         status;
    logic               last;
    logic [4:0]         length_now;

    list_scoreboard sb;
    longint         cycles;
    bit             long_stall;   // receiver hold-off window, set by stimulus
    bit             stim_done;

    ordered_record_list_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .entry_key(entry_key),
        .name_part0(name_part0), .name_part1(name_part1), .name_part2(name_part2),
        .position(position),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_key(out_key), .out_name0(out_name0), .out_name1(out_name1),
        .out_name2(out_name2), .status(status), .last(last), .length_now(length_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // keys are mostly drawn from a small pool so that deletes hit often
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
            2: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: return $urandom;
        endcase
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(op_t o, logic [31:0] k, logic [159:0] nm, logic [7:0] pos);
        in_valid   <= 1'b1;
        op         <= o;
        entry_key  <= k;
        name_part0 <= nm[63:0];
        name_part1 <= nm[127:64];
        name_part2 <= nm[159:128];
        position   <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(o, k, nm, pos);
    endtask

    task automatic idle_sender(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random(logic [159:0] nm);
        int  r;
        op_t o;
        r = $urandom_range(0, 99);
        // insert-heavy so the list spends time near full, and dumps stay regular
        if (r < 50)
            o = OP_INSERT;
        else if (r < 80)
            o = OP_DELETE;
        else if (r < 95)
            o = OP_DUMP;
        else
            o = OP_NONE;
        send_request(o, pick_key(), nm,
                     $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 18)));
    endtask

    function automatic logic [159:0] rand_name();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // wait until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        sb         = new();
        stim_done  = 0;
        long_stall = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_INSERT;
        entry_key  = '0;
        name_part0 = '0;
        name_part1 = '0;
        name_part2 = '0;
        position   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dump, delete on empty list, insert into empty list at
        // an odd position, extreme keys and names, unused op, full list overflow
        send_request(OP_DUMP, 0, 0, 0);
        send_request(OP_DELETE, 32'h8000_0000, 0, 0);
        send_request(OP_INSERT, 32'h7FFF_FFFF, {160{1'b1}}, 8'd200);
        send_request(OP_INSERT, 32'h8000_0000, 160'd0, 8'd1);
        send_request(OP_INSERT, 32'd0, rand_name(), 8'd2);
        send_request(OP_INSERT, 32'hFFFF_FFFF, rand_name(), 8'd255);
        send_request(OP_INSERT, 32'd5, rand_name(), 8'd0);
        send_request(OP_NONE, 32'd5, rand_name(), 8'd1);
        send_request(OP_DUMP, 0, 0, 0);
        send_request(OP_DELETE, 32'h7FFF_FFFF, 0, 0);
        send_request(OP_DELETE, 32'd12345, 0, 0);
        for (int i = 0; i < 12; i++)
            send_request(OP_INSERT, 32'd5, rand_name(), 8'($urandom_range(0, 20)));
        send_request(OP_INSERT, 32'd9, rand_name(), 8'd1);
        send_request(OP_DUMP, 0, 0, 0);

        // receiver holds off while requests keep coming, filling the block
        long_stall = 1;
        for (int i = 0; i < 6; i++)
            send_request(OP_DELETE, 32'd5, 0, 0);
        long_stall = 0;
        // sender pause until all results are back
        drain();

        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            idle_sender(gap_len());
            send_random(rand_name());
            if (i == RANDOM_REQS / 2)
                drain();
        end
        drain();
        stim_done = 1;
    end

    // receiver with random stalls and a single long hold-off window
    initial
    begin
        int hold;
        bit stall_done;
        stall_done = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_stall && !stall_done)
            begin
                out_ready <= 1'b0;
                repeat (60) @(posedge clk);
                stall_done = 1;
            end
            hold = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // result checking on each accepted result
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_key, out_name0, out_name1, out_name2, status, last,
                            length_now);

    // end of run and timeout watch
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (stim_done)
            begin
                if (sb.errors == 0 && sb.pending.size() == 0)
                    $display("tb: PASS");
                else
                    $display("tb: FAIL");
                $finish;
            end
            else if (cycles > CYCLE_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end
endmodule
